[sv/pcsmb_pkg.sv]
// ----------------------------------------------------------------------------
// pcsmb_pkg
// shared types, codes and constants of the point cloud to scan block
// ----------------------------------------------------------------------------
package pcsmb_pkg;

    localparam int NUM_BINS_DEF = 360;
    localparam int COORD_W      = 18;
    localparam int IDX_W        = 9;
    localparam int DIST_W       = 18;
    localparam int ANG_W        = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;   // cordic datapath width
    localparam int SCALE_SH     = 12;   // coordinates times 4096
    localparam int SQRT_STEPS   = 18;
    localparam int ENTRY_W      = 2 + DIST_W;
    localparam int PADDR_W      = 5;

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic [1:0] ST_NODATA = 2'd0;
    localparam logic [1:0] ST_FREE   = 2'd1;
    localparam logic [1:0] ST_DIST   = 2'd2;

    localparam logic [2:0] REG_FLOOR = 3'd0;
    localparam logic [2:0] REG_CEIL  = 3'd1;
    localparam logic [2:0] REG_FWD   = 3'd2;
    localparam logic [2:0] REG_LEFT  = 3'd3;
    localparam logic [2:0] REG_RIGHT = 3'd4;
    localparam logic [2:0] REG_WRAPS = 3'd5;
    localparam logic [2:0] REG_SPARE = 3'd6;

    localparam logic [ANG_W-1:0] ANG_HALF    = 32'h8000_0000;
    localparam logic [ANG_W-1:0] ANG_QUARTER = 32'h4000_0000;
    localparam logic [ANG_W-1:0] ANG_3QUART  = 32'hC000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] floor_mm;
        logic signed [COORD_W-1:0] ceil_mm;
        logic signed [COORD_W-1:0] fwd_mm;
        logic [IDX_W-1:0]          left_bin;
        logic [IDX_W-1:0]          right_bin;
        logic                      wraps;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [IDX_W-1:0]          idx;
    } entry_t;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] radius;
        logic [ANG_W-1:0]  angle;
    } polar_res_t;

    function automatic logic [ANG_W-1:0] atan_turns(input logic [4:0] i);
        logic [ANG_W-1:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[sv/pcsmb_front.sv]
// ----------------------------------------------------------------------------
// pcsmb_front
// accepts input transactions, filters points by height and range, queues work
// ----------------------------------------------------------------------------
module pcsmb_front
    import pcsmb_pkg::*;
(
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                kind,
    input  logic signed [COORD_W-1:0] x_mm,
    input  logic signed [COORD_W-1:0] y_mm,
    input  logic signed [COORD_W-1:0] z_mm,
    input  logic [IDX_W-1:0]          bin_index,
    input  cfg_t                      cfg,
    input  logic                      q_full,
    output logic                      q_push,
    output entry_t                    q_entry
);

    logic keep;

    always_comb
    begin
        case (kind)
            KIND_POINT: keep = (z_mm > cfg.floor_mm) && (z_mm < cfg.ceil_mm)
                               && (x_mm < cfg.fwd_mm);
            KIND_CLEAR: keep = 1'b1;
            KIND_READ:  keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    // dropped points and unknown kinds are accepted and vanish here
    assign in_stall      = q_full;
    assign q_push        = in_valid && !q_full && keep;
    assign q_entry.op    = kind;
    assign q_entry.x     = x_mm;
    assign q_entry.y     = y_mm;
    assign q_entry.idx   = bin_index;

endmodule

[sv/pcsmb_fifo.sv]
// ----------------------------------------------------------------------------
// pcsmb_fifo
// two-entry queue between the front classifier and the back sequencer
// ----------------------------------------------------------------------------
module pcsmb_fifo
    import pcsmb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t head
);

    entry_t     slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_data;
    end

endmodule

[sv/pcsmb_polar.sv]
// ----------------------------------------------------------------------------
// pcsmb_polar
// iterative polar conversion: bit-serial square root and cordic vectoring
// ----------------------------------------------------------------------------
module pcsmb_polar
    import pcsmb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] x,
    input  logic signed [COORD_W-1:0] y,
    output polar_res_t                res
);

    localparam int SQ_W = 2 * COORD_W;

    logic                   busy_reg;
    logic                   done_reg;
    logic [4:0]             cnt_reg;
    logic [SQ_W-1:0]        sqx_reg, sqy_reg;
    logic [SQ_W-1:0]        n_reg;
    logic [19:0]            rem_reg;
    logic [DIST_W-1:0]      root_reg;
    logic signed [CW-1:0]   cx_reg, cy_reg;
    logic [ANG_W-1:0]       cz_reg;
    logic                   axis_reg;
    logic [ANG_W-1:0]       axis_ang_reg;

    logic signed [CW-1:0]   xe, ye, xs, ys;
    logic signed [2*COORD_W-1:0] px, py;
    logic [20:0]            rem_sh;
    logic [21:0]            trial;

    assign xe = CW'(x);
    assign ye = CW'(y);
    assign px = x * x;
    assign py = y * y;
    assign xs = cx_reg >>> cnt_reg;
    assign ys = cy_reg >>> cnt_reg;
    assign rem_sh = {rem_reg[18:0], n_reg[SQ_W-1 -: 2]};
    assign trial  = {1'b0, rem_sh} - {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sqx_reg <= SQ_W'(px);
            sqy_reg <= SQ_W'(py);
            // exact axis angles bypass the cordic result
            axis_reg <= (x == '0) || (y == '0);
            if (y == '0)
                axis_ang_reg <= (x < 0) ? ANG_HALF : '0;
            else
                axis_ang_reg <= (y > 0) ? ANG_QUARTER : ANG_3QUART;
            if (x < 0)
            begin
                cx_reg <= (-xe) <<< SCALE_SH;
                cy_reg <= (-ye) <<< SCALE_SH;
                cz_reg <= ANG_HALF;
            end
            else
            begin
                cx_reg <= xe <<< SCALE_SH;
                cy_reg <= ye <<< SCALE_SH;
                cz_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (cy_reg < 0)
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - atan_turns(cnt_reg);
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + atan_turns(cnt_reg);
            end
            if (cnt_reg == 5'd0)
            begin
                n_reg    <= sqx_reg + sqy_reg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (cnt_reg <= 5'(SQRT_STEPS))
            begin
                n_reg <= {n_reg[SQ_W-3:0], 2'b00};
                if (!trial[21])
                begin
                    rem_reg  <= trial[19:0];
                    root_reg <= {root_reg[DIST_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[19:0];
                    root_reg <= {root_reg[DIST_W-2:0], 1'b0};
                end
            end
        end
    end

    assign res.done   = done_reg;
    assign res.radius = root_reg;
    assign res.angle  = axis_reg ? axis_ang_reg : cz_reg;

endmodule

[sv/pcsmb_back.sv]
// ----------------------------------------------------------------------------
// pcsmb_back
// bin memory and sequencer: point update, frame clear, bin read, reset sweep
// ----------------------------------------------------------------------------
module pcsmb_back
    import pcsmb_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_empty,
    input  entry_t            q_head,
    output logic              q_pop,
    output logic              polar_start,
    input  polar_res_t        polar,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        bin_status,
    output logic [DIST_W-1:0] bin_distance_mm
);

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int PW    = ANG_W + BIN_W + 1;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_POLAR = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_RMW   = 3'd5;
    localparam logic [2:0] S_CLEAR = 3'd6;
    localparam logic [2:0] S_ROUT  = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [BIN_W-1:0]   addr_reg, addr_next;
    logic [1:0]         op_reg;
    logic               oor_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [ANG_W-1:0]   ang_reg;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         ost_reg;
    logic [DIST_W-1:0]  odist_reg;
    logic               out_load;

    logic [ENTRY_W-1:0] mem [NUM_BINS];
    logic [ENTRY_W-1:0] rdata_reg;
    logic               mem_we;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               in_fov;
    logic [PW-1:0]      prod;
    logic [1:0]         rst_st;
    logic               last_bin;

    assign prod     = PW'(ang_reg) * PW'(NUM_BINS);
    assign rst_st   = rdata_reg[ENTRY_W-1 -: 2];
    assign last_bin = (addr_reg == BIN_W'(NUM_BINS - 1));

    always_comb
    begin
        if (cfg.wraps)
            in_fov = (32'(addr_reg) < 32'(cfg.left_bin))
                     || (32'(addr_reg) >= 32'(cfg.right_bin));
        else
            in_fov = (32'(addr_reg) >= 32'(cfg.right_bin))
                     && (32'(addr_reg) < 32'(cfg.left_bin));
    end

    assign q_pop       = (state_reg == S_IDLE) && !q_empty;
    assign polar_start = q_pop && (q_head.op == KIND_POINT);
    assign out_load    = (state_reg == S_ROUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        mem_we     = 1'b0;
        mem_wdata  = '0;
        unique case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {ST_NODATA, {DIST_W{1'b0}}};
                addr_next = addr_reg + BIN_W'(1);
                if (last_bin)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_head.op)
                        KIND_POINT: state_next = S_POLAR;
                        KIND_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            addr_next  = BIN_W'({{BIN_W{1'b0}}, q_head.idx});
                            state_next = S_RD;
                        end
                    endcase
                end
            end
            S_POLAR:
            begin
                if (polar.done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                addr_next  = prod[ANG_W +: BIN_W];
                state_next = S_RD;
            end
            S_RD:
                state_next = (op_reg == KIND_POINT) ? S_RMW : S_ROUT;
            S_RMW:
            begin
                if ((rst_st == ST_FREE)
                    || ((rst_st == ST_DIST) && (dist_reg < rdata_reg[DIST_W-1:0])))
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {ST_DIST, dist_reg};
                end
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {(in_fov ? ST_FREE : ST_NODATA), {DIST_W{1'b0}}};
                addr_next = addr_reg + BIN_W'(1);
                if (last_bin)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_ROUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg  <= q_head.op;
            oor_reg <= (32'(q_head.idx) >= 32'(NUM_BINS));
        end
        if (polar.done)
        begin
            dist_reg <= polar.radius;
            ang_reg  <= polar.angle;
        end
        if (out_load)
        begin
            if (oor_reg || (rst_st == ST_NODATA))
            begin
                ost_reg   <= ST_NODATA;
                odist_reg <= '0;
            end
            else
            begin
                ost_reg   <= rst_st;
                odist_reg <= (rst_st == ST_DIST) ? rdata_reg[DIST_W-1:0] : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= mem_wdata;
        rdata_reg <= mem[addr_reg];
    end

    assign out_valid       = out_valid_reg;
    assign bin_status      = ost_reg;
    assign bin_distance_mm = odist_reg;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("queue popped outside idle");
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        polar.done |-> (state_reg == S_POLAR))
        else $error("polar result with no point waiting");
    a_dist_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (mem_wdata[ENTRY_W-1 -: 2] == ST_DIST)) |-> (state_reg == S_RMW))
        else $error("distance written outside update");
    a_idle_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("memory written while idle");
`endif

endmodule

[sv/point_cloud_to_scan_min_bins_core.sv]
// ----------------------------------------------------------------------------
// point_cloud_to_scan_min_bins_core
// 3d points to a planar scan keeping the nearest distance per angular bin
// ----------------------------------------------------------------------------
// channel  direction  handshake                  payload
// in       input      in_valid / in_stall        kind, x_mm, y_mm, z_mm, bin_index
// out      output     out_valid / out_stall      bin_status, bin_distance_mm
// cfg      input      psel / penable / pwrite    paddr, pwdata, prdata, pready
//
// a kept point runs 30 cordic steps in the single polar unit, then the bin
// multiply, memory read and write; a read is a memory read then the output
// register; a clear makes one memory write per bin
// after reset a clearing pass writes every bin before the first item
// a two-entry queue lets the input take transactions while the back end works
// or while a read result waits on out_stall
// ----------------------------------------------------------------------------
module point_cloud_to_scan_min_bins_core
    import pcsmb_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                kind,
    input  logic signed [COORD_W-1:0] x_mm,
    input  logic signed [COORD_W-1:0] y_mm,
    input  logic signed [COORD_W-1:0] z_mm,
    input  logic [IDX_W-1:0]          bin_index,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                bin_status,
    output logic [DIST_W-1:0]         bin_distance_mm,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic       q_full, q_push, q_empty, q_pop;
    entry_t     q_entry, q_head;
    logic       polar_start;
    polar_res_t polar;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.floor_mm  <= 18'sd100;
            cfg_reg.ceil_mm   <= 18'sd2000;
            cfg_reg.fwd_mm    <= 18'sd10000;
            cfg_reg.left_bin  <= '0;
            cfg_reg.right_bin <= '0;
            cfg_reg.wraps     <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FLOOR: cfg_reg.floor_mm  <= pwdata[COORD_W-1:0];
                REG_CEIL:  cfg_reg.ceil_mm   <= pwdata[COORD_W-1:0];
                REG_FWD:   cfg_reg.fwd_mm    <= pwdata[COORD_W-1:0];
                REG_LEFT:  cfg_reg.left_bin  <= pwdata[IDX_W-1:0];
                REG_RIGHT: cfg_reg.right_bin <= pwdata[IDX_W-1:0];
                REG_WRAPS: cfg_reg.wraps     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FLOOR: prdata = {{(32-COORD_W){1'b0}}, cfg_reg.floor_mm};
            REG_CEIL:  prdata = {{(32-COORD_W){1'b0}}, cfg_reg.ceil_mm};
            REG_FWD:   prdata = {{(32-COORD_W){1'b0}}, cfg_reg.fwd_mm};
            REG_LEFT:  prdata = {{(32-IDX_W){1'b0}}, cfg_reg.left_bin};
            REG_RIGHT: prdata = {{(32-IDX_W){1'b0}}, cfg_reg.right_bin};
            REG_WRAPS: prdata = {31'b0, cfg_reg.wraps};
            default:   prdata = '0;
        endcase
    end

    pcsmb_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .x_mm      (x_mm),
        .y_mm      (y_mm),
        .z_mm      (z_mm),
        .bin_index (bin_index),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    pcsmb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_entry),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    pcsmb_polar u_polar (
        .clk   (clk),
        .rst_n (rst_n),
        .start (polar_start),
        .x     (q_head.x),
        .y     (q_head.y),
        .res   (polar)
    );

    pcsmb_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .polar_start     (polar_start),
        .polar           (polar),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .bin_status      (bin_status),
        .bin_distance_mm (bin_distance_mm)
    );

endmodule

[bench/pcsmb_scan_checker.sv]
// ----------------------------------------------------------------------------
// pcsmb_scan_checker
// watches the point, register and result channels of the scan core, keeps its
// own copy of the angular bins and compares every bin read against it
// ----------------------------------------------------------------------------
module pcsmb_scan_checker
    import pcsmb_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [1:0]                kind,
    input  logic signed [COORD_W-1:0] x_mm,
    input  logic signed [COORD_W-1:0] y_mm,
    input  logic signed [COORD_W-1:0] z_mm,
    input  logic [IDX_W-1:0]          bin_index,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [1:0]                bin_status,
    input  logic [DIST_W-1:0]         bin_distance_mm,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [31:0]               pwdata,
    input  logic                      pready,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]        status;
        logic [DIST_W-1:0] distance;
    } bin_read_t;

    bin_read_t         bin_reads_q[$];
    logic [1:0]        scan_status [NUM_BINS];
    logic [DIST_W-1:0] scan_dist [NUM_BINS];
    cfg_t              cfg;

    function automatic logic [ANG_W-1:0] point_angle(longint px, longint py);
        longint ax, ay, az, sx, sy;
        if (py == 0)
            return (px < 0) ? ANG_HALF : '0;
        if (px == 0)
            return (py > 0) ? ANG_QUARTER : ANG_3QUART;
        ax = px;
        ay = py;
        az = 0;
        if (ax < 0)
        begin
            ax = -ax;
            ay = -ay;
            az = longint'(ANG_HALF);
        end
        ax = ax * 4096;
        ay = ay * 4096;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            sx = ax >>> i;
            sy = ay >>> i;
            if (ay < 0)
            begin
                ax = ax - sy;
                ay = ay + sx;
                az = az - longint'(atan_turns(i[4:0]));
            end
            else
            begin
                ax = ax + sy;
                ay = ay - sx;
                az = az + longint'(atan_turns(i[4:0]));
            end
        end
        return az[ANG_W-1:0];
    endfunction

    function automatic longint planar_dist(longint sq);
        longint r, t;
        r = 0;
        for (int b = 20; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= sq)
                r = t;
        end
        return r;
    endfunction

    task automatic apply_point();
        longint    px, py, pz, d;
        logic [63:0] prod;
        int        b;
        px = longint'(x_mm);
        py = longint'(y_mm);
        pz = longint'(z_mm);
        if (pz > longint'(cfg.floor_mm) && pz < longint'(cfg.ceil_mm)
            && px < longint'(cfg.fwd_mm))
        begin
            d = planar_dist(px * px + py * py);
            prod = {32'd0, point_angle(px, py)} * 64'(NUM_BINS);
            b = int'(prod[63:32]);
            if (scan_status[b] == ST_FREE
                || (scan_status[b] == ST_DIST && d < longint'(scan_dist[b])))
            begin
                scan_status[b] = ST_DIST;
                scan_dist[b] = d[DIST_W-1:0];
            end
        end
    endtask

    task automatic clear_scan();
        int  lft, rgt;
        logic inside_fov;
        lft = (cfg.left_bin < NUM_BINS) ? int'(cfg.left_bin) : NUM_BINS;
        rgt = (cfg.right_bin < NUM_BINS) ? int'(cfg.right_bin) : NUM_BINS;
        for (int i = 0; i < NUM_BINS; i++)
        begin
            if (cfg.wraps)
                inside_fov = (i < lft) || (i >= rgt);
            else
                inside_fov = (i >= rgt) && (i < lft);
            scan_status[i] = inside_fov ? ST_FREE : ST_NODATA;
            scan_dist[i] = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bin_read_t rd, want;
        if (!rst_n)
        begin
            cfg.floor_mm  = 18'sd100;
            cfg.ceil_mm   = 18'sd2000;
            cfg.fwd_mm    = 18'sd10000;
            cfg.left_bin  = '0;
            cfg.right_bin = '0;
            cfg.wraps     = 1'b0;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                scan_status[i] = ST_NODATA;
                scan_dist[i] = '0;
            end
            bin_reads_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_FLOOR: cfg.floor_mm  = pwdata[COORD_W-1:0];
                    REG_CEIL:  cfg.ceil_mm   = pwdata[COORD_W-1:0];
                    REG_FWD:   cfg.fwd_mm    = pwdata[COORD_W-1:0];
                    REG_LEFT:  cfg.left_bin  = pwdata[IDX_W-1:0];
                    REG_RIGHT: cfg.right_bin = pwdata[IDX_W-1:0];
                    REG_WRAPS: cfg.wraps     = pwdata[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                case (kind)
                    KIND_POINT: apply_point();
                    KIND_CLEAR: clear_scan();
                    KIND_READ:
                    begin
                        rd = '0;
                        if (bin_index < NUM_BINS && scan_status[bin_index] != ST_NODATA)
                        begin
                            rd.status = scan_status[bin_index];
                            if (rd.status == ST_DIST)
                                rd.distance = scan_dist[bin_index];
                        end
                        bin_reads_q.push_back(rd);
                    end
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (bin_reads_q.size() == 0)
                begin
                    $error("unexpected result transaction: status %0d distance %0d",
                           bin_status, bin_distance_mm);
                    fail_count++;
                end
                else
                begin
                    want = bin_reads_q.pop_front();
                    if (bin_status !== want.status)
                    begin
                        $error("bin_status: expected %0d, actual %0d",
                               want.status, bin_status);
                        fail_count++;
                    end
                    if (bin_distance_mm !== want.distance)
                    begin
                        $error("bin_distance_mm: expected %0d, actual %0d",
                               want.distance, bin_distance_mm);
                        fail_count++;
                    end
                end
            end
        end
        pending = bin_reads_q.size();
    end

endmodule

[bench/point_cloud_to_scan_min_bins_core_test.sv]
// ----------------------------------------------------------------------------
// point_cloud_to_scan_min_bins_core_test
// drives points, frame clears and bin reads under changing register settings,
// with bursty input and a stalling receiver; the checker does the comparing
// ----------------------------------------------------------------------------
module point_cloud_to_scan_min_bins_core_test
    import pcsmb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // covers a full back end plus two queued frame clears
    localparam int SETTLE_CYCLES = 1500;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [1:0]                kind = KIND_POINT;
    logic signed [COORD_W-1:0] x_mm = '0;
    logic signed [COORD_W-1:0] y_mm = '0;
    logic signed [COORD_W-1:0] z_mm = '0;
    logic [IDX_W-1:0]          bin_index = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [1:0]                bin_status;
    logic [DIST_W-1:0]         bin_distance_mm;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;

    int fail_count;
    int pending;
    int burst_left = 0;
    int quiet_cycles = 0;
    int cur_floor = 100;
    int cur_ceil = 2000;
    int cur_fwd = 10000;

    point_cloud_to_scan_min_bins_core DUT (.*);

    pcsmb_scan_checker checker_i (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic write_reg(logic [2:0] idx, int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FLOOR: cur_floor = value;
            REG_CEIL:  cur_ceil = value;
            REG_FWD:   cur_fwd = value;
            default: ;
        endcase
    endtask

    task automatic send_item(logic [1:0] k, int px, int py, int pz, int idx);
        in_valid <= 1'b1;
        kind <= k;
        x_mm <= COORD_W'(px);
        y_mm <= COORD_W'(py);
        z_mm <= COORD_W'(pz);
        bin_index <= IDX_W'(idx);
        do @(posedge clk); while (in_stall);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
        else
            burst_left--;
    endtask

    task automatic settle();
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int rand_coord();
        if ($urandom_range(0, 9) == 0)
            return int'(signed'(18'($urandom)));
        return $urandom_range(0, 12000) - 6000;
    endfunction

    function automatic int rand_height();
        if ($urandom_range(0, 4) != 0 && cur_floor + 1 < cur_ceil)
            return cur_floor + 1 + int'($urandom_range(0, cur_ceil - cur_floor - 2));
        return int'(signed'(18'($urandom)));
    endfunction

    function automatic int rand_field();
        case ($urandom_range(0, 3))
            0: return -131072;
            1: return 131071;
            default: return int'(signed'(18'($urandom)));
        endcase
    endfunction

    // receiver: stall patterns that change over the run, and one long hold-off so
    // the core backs up into its input
    initial
    begin
        int cyc;
        int mode;
        cyc = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == 4000)
            begin
                out_stall <= 1'b1;
                repeat (600) @(posedge clk);
            end
            if (cyc % 200 == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("point_cloud_to_scan_min_bins_core verification failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        // directed: axis points, extremes, filter edges, odd reads
        write_reg(REG_LEFT, 300);
        write_reg(REG_RIGHT, 10);
        write_reg(REG_WRAPS, 0);
        send_item(KIND_READ, 0, 0, 0, 100);
        send_item(KIND_CLEAR, 0, 0, 0, 0);
        send_item(KIND_POINT, 0, 0, 500, 0);
        send_item(KIND_POINT, 1000, 0, 500, 0);
        send_item(KIND_POINT, -1000, 0, 500, 0);
        send_item(KIND_POINT, 0, 1000, 500, 0);
        send_item(KIND_POINT, 0, -1000, 500, 0);
        send_item(KIND_POINT, 700, 700, 500, 0);
        send_item(KIND_POINT, -131072, 131071, 1999, 0);
        send_item(KIND_POINT, -131072, -131072, 101, 0);
        send_item(KIND_POINT, 500, 600, 100, 0);
        send_item(KIND_POINT, 9999, -3, 2000, 0);
        send_item(KIND_POINT, 10000, 5000, 500, 0);
        send_item(KIND_RSVD, 100, 100, 500, 90);
        send_item(KIND_READ, 0, 0, 0, 0);
        send_item(KIND_READ, 0, 0, 0, 45);
        send_item(KIND_READ, 0, 0, 0, 90);
        send_item(KIND_READ, 0, 0, 0, 180);
        send_item(KIND_READ, 0, 0, 0, 135);
        send_item(KIND_READ, 0, 0, 0, 224);
        send_item(KIND_READ, 0, 0, 0, 270);
        send_item(KIND_READ, 0, 0, 0, 359);
        send_item(KIND_READ, 0, 0, 0, 511);
        in_valid <= 1'b0;

        // random phases, each under its own register setting
        for (int ph = 0; ph < 12; ph++)
        begin
            settle();
            case (ph)
                0: begin write_reg(REG_FLOOR, -131072); write_reg(REG_CEIL, 131071);
                         write_reg(REG_FWD, 131071); end
                1: begin write_reg(REG_FLOOR, 131071); write_reg(REG_CEIL, -131072);
                         write_reg(REG_FWD, -131072); end
                default: begin
                    write_reg(REG_FLOOR, $urandom_range(0, 2000) - 1000);
                    write_reg(REG_CEIL, $urandom_range(0, 3000));
                    write_reg(REG_FWD, (ph % 3 == 0) ? rand_field()
                                                      : $urandom_range(0, 12000) - 2000);
                end
            endcase
            write_reg(REG_LEFT, (ph == 1) ? 511 : (ph == 2) ? 0 : $urandom_range(0, 359));
            write_reg(REG_RIGHT, (ph == 1) ? 0 : (ph == 2) ? 359 :
                                 (ph == 5) ? 511 : $urandom_range(0, 359));
            write_reg(REG_WRAPS, ph % 2);
            if (ph == 4)
                write_reg(REG_SPARE, 32'hFFFF_FFFF);
            send_item(KIND_CLEAR, 0, 0, 0, 0);
            for (int n = 0; n < 130; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    send_item(KIND_POINT, rand_coord(), rand_coord(), rand_height(), 0);
                else if (r < 90)
                    send_item(KIND_READ, rand_coord(), rand_coord(), rand_coord(),
                              ($urandom_range(0, 19) == 0) ? $urandom_range(360, 511)
                                                           : $urandom_range(0, 359));
                else if (r < 94)
                    send_item(KIND_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                              $urandom_range(0, 511));
                else
                    send_item(KIND_RSVD, rand_field(), rand_field(), rand_field(),
                              $urandom_range(0, 511));
            end
            in_valid <= 1'b0;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("point_cloud_to_scan_min_bins_core verification clean");
        else
            $display("point_cloud_to_scan_min_bins_core verification failed");
        $finish;
    end

endmodule
